>>> rtl/char_lcd_nibble_writer_unit_assert.svh
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_unit_assert.svh
// assertion macros used by the checker file of the lcd nibble writer
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITER_UNIT_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define CNW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define CNW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/cnw_pkg.sv
// ----------------------------------------------------------------------------
// cnw_pkg
// types, constants and byte tables of the character lcd nibble writer
// ----------------------------------------------------------------------------
package cnw_pkg;

  // default display geometry
  localparam int ROW_CHARS_DEF = 20;
  localparam int ROW_COUNT_DEF = 4;

  // job queue between front and back end
  localparam int QUEUE_DEPTH = 4;

  // lcd command bytes and special characters
  localparam logic [7:0] NEWLINE   = 8'h0A;
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h02;
  localparam logic [7:0] CMD_DDRAM = 8'h80;

  // configuration register indexes
  localparam logic [1:0] REG_STROBE_WIDTH = 2'd0;
  localparam logic [1:0] REG_BYTE_WAIT    = 2'd1;
  localparam logic [1:0] REG_COMMAND_WAIT = 2'd2;

  // configuration reset values
  localparam logic [7:0]  STROBE_WIDTH_RST = 8'd1;
  localparam logic [9:0]  BYTE_WAIT_RST    = 10'd50;
  localparam logic [15:0] COMMAND_WAIT_RST = 16'd2000;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_BEGIN = 2'd1,
    ACT_CHAR  = 2'd2,
    ACT_END   = 2'd3
  } action_t;

  // what the back end has to send for one accepted item
  typedef enum logic [2:0] {
    JOB_INIT      = 3'd0,
    JOB_BEGIN     = 3'd1,
    JOB_CHAR      = 3'd2,
    JOB_CHAR_ROW  = 3'd3,
    JOB_CHAR_WRAP = 3'd4,
    JOB_END       = 3'd5
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  code;
    logic [7:0]  row_cmd;
  } job_t;

  typedef struct packed {
    logic [7:0]  strobe_width_us;
    logic [9:0]  byte_wait_us;
    logic [15:0] command_wait_us;
  } cfg_t;

  typedef struct packed {
    logic        is_data;
    logic [7:0]  value;
  } bus_byte_t;

  // ddram start address of each row
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    case (row)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      2'd3:    base = 8'h54;
      default: base = 8'h00;
    endcase
    return base;
  endfunction

  // power-on command sequence
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h32;
      3'd2:    b = 8'h28;
      3'd3:    b = 8'h0C;
      3'd4:    b = 8'h04;
      3'd5:    b = CMD_CLEAR;
      3'd6:    b = CMD_HOME;
      default: b = CMD_HOME;
    endcase
    return b;
  endfunction

  // number of bus bytes in a job
  function automatic logic [2:0] job_bytes(input job_kind_t kind);
    logic [2:0] n;
    case (kind)
      JOB_INIT:      n = 3'd7;
      JOB_BEGIN:     n = 3'd2;
      JOB_CHAR:      n = 3'd1;
      JOB_CHAR_ROW:  n = 3'd2;
      JOB_CHAR_WRAP: n = 3'd4;
      JOB_END:       n = 3'd1;
      default:       n = 3'd1;
    endcase
    return n;
  endfunction

  // byte number idx of a job
  function automatic bus_byte_t job_byte(input job_t job, input logic [2:0] idx);
    bus_byte_t b;
    b.is_data = 1'b0;
    b.value   = CMD_DDRAM;
    case (job.kind)
      JOB_INIT: begin
        b.value = init_byte(idx);
      end
      JOB_BEGIN: begin
        b.value = (idx == 3'd0) ? CMD_CLEAR : CMD_HOME;
      end
      JOB_CHAR: begin
        b.is_data = 1'b1;
        b.value   = job.code;
      end
      JOB_CHAR_ROW: begin
        b.is_data = (idx == 3'd0);
        b.value   = (idx == 3'd0) ? job.code : job.row_cmd;
      end
      JOB_CHAR_WRAP: begin
        case (idx)
          3'd0: begin
            b.is_data = 1'b1;
            b.value   = job.code;
          end
          3'd1:    b.value = CMD_DDRAM;
          3'd2:    b.value = CMD_CLEAR;
          default: b.value = CMD_HOME;
        endcase
      end
      JOB_END: begin
        b.value = CMD_DDRAM;
      end
      default: begin
        b.value = CMD_DDRAM;
      end
    endcase
    return b;
  endfunction

endpackage

>>> rtl/char_lcd_nibble_writer_unit.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_unit
// 4-bit bus nibble writer for a character lcd
// ----------------------------------------------------------------------------
// Each action on the input stream turns into the nibble writes it needs,
// high nibble first, sent one nibble per clock while the receiver is ready:
// init gives 14 nibbles, begin 4, a character 2, 4 at a row change or 8 at a
// screen wrap, end 2; a newline or a character outside a message gives none.
// The nibble output is registered. A four-entry job queue sits in front of
// the nibble sequencer, so actions are taken while earlier ones are still
// being sent; the input stalls only when that queue is full. Configuration
// writes are always ready and take effect on the next nibble computed.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_unit #(
  parameter int ROW_CHARS = cnw_pkg::ROW_CHARS_DEF,
  parameter int ROW_COUNT = cnw_pkg::ROW_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // action stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic [1:0]  in_tuser,   // [1:0] action
  // nibble stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] nibble, [20:4] wait_after_us, rest zero
  output logic        out_tuser,  // [0] reg_select
  output logic        out_tlast,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cnw_pkg::cfg_t cfg_r;
  logic          push;
  cnw_pkg::job_t push_job;
  logic          q_full;
  logic          q_pop;
  logic          q_nonempty;
  cnw_pkg::job_t q_head;
  logic [3:0]    nibble;
  logic [16:0]   wait_after_us;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.strobe_width_us <= cnw_pkg::STROBE_WIDTH_RST;
      cfg_r.byte_wait_us    <= cnw_pkg::BYTE_WAIT_RST;
      cfg_r.command_wait_us <= cnw_pkg::COMMAND_WAIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        cnw_pkg::REG_STROBE_WIDTH: cfg_r.strobe_width_us <= cfg_data[7:0];
        cnw_pkg::REG_BYTE_WAIT:    cfg_r.byte_wait_us    <= cfg_data[9:0];
        cnw_pkg::REG_COMMAND_WAIT: cfg_r.command_wait_us <= cfg_data;
        default:                   cfg_r                 <= cfg_r;
      endcase
    end
  end

  // front end: classify actions
  cnw_front #(
    .ROW_CHARS (ROW_CHARS),
    .ROW_COUNT (ROW_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .action    (in_tuser),
    .char_code (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  // job queue
  cnw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  // back end: nibble sequencer
  cnw_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_nonempty    (q_nonempty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .reg_select    (out_tuser),
    .nibble        (nibble),
    .wait_after_us (wait_after_us),
    .last          (out_tlast)
  );

  assign out_tdata = {3'b000, wait_after_us, nibble};

endmodule

>>> rtl/cnw_front.sv
// ----------------------------------------------------------------------------
// cnw_front
// accepts actions, tracks cursor and message state, queues bus jobs
// ----------------------------------------------------------------------------
module cnw_front #(
  parameter int ROW_CHARS = cnw_pkg::ROW_CHARS_DEF,
  parameter int ROW_COUNT = cnw_pkg::ROW_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    action,
  input  logic [7:0]    char_code,
  input  logic          q_full,
  output logic          push,
  output cnw_pkg::job_t push_job
);

  localparam int CW = $clog2(ROW_CHARS);
  localparam int RW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam logic [CW-1:0] COL_LAST = CW'(ROW_CHARS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROW_COUNT - 1);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          stopped_r, stopped_nxt;
  logic          accept;
  logic [1:0]    next_row;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign next_row = 2'(row_r) + 2'd1;

  // classify the action and update the cursor
  always_comb begin
    col_nxt          = col_r;
    row_nxt          = row_r;
    stopped_nxt      = stopped_r;
    push             = 1'b0;
    push_job.kind    = cnw_pkg::JOB_END;
    push_job.code    = char_code;
    push_job.row_cmd = cnw_pkg::CMD_DDRAM | cnw_pkg::row_base(next_row);
    if (accept) begin
      case (cnw_pkg::action_t'(action))
        cnw_pkg::ACT_INIT: begin
          push          = 1'b1;
          push_job.kind = cnw_pkg::JOB_INIT;
          col_nxt       = '0;
          row_nxt       = '0;
          stopped_nxt   = 1'b1;
        end
        cnw_pkg::ACT_BEGIN: begin
          push          = 1'b1;
          push_job.kind = cnw_pkg::JOB_BEGIN;
          col_nxt       = '0;
          row_nxt       = '0;
          stopped_nxt   = 1'b0;
        end
        cnw_pkg::ACT_CHAR: begin
          if (!stopped_r) begin
            if (char_code == cnw_pkg::NEWLINE) begin
              stopped_nxt = 1'b1;
            end else if (col_r == COL_LAST && row_r == ROW_LAST) begin
              // screen full: home, clear and count from the top
              push          = 1'b1;
              push_job.kind = cnw_pkg::JOB_CHAR_WRAP;
              col_nxt       = '0;
              row_nxt       = '0;
            end else if (col_r == COL_LAST) begin
              // row full: move to the start of the next row
              push          = 1'b1;
              push_job.kind = cnw_pkg::JOB_CHAR_ROW;
              col_nxt       = '0;
              row_nxt       = row_r + 1'b1;
            end else begin
              push          = 1'b1;
              push_job.kind = cnw_pkg::JOB_CHAR;
              col_nxt       = col_r + 1'b1;
            end
          end
        end
        cnw_pkg::ACT_END: begin
          push          = 1'b1;
          push_job.kind = cnw_pkg::JOB_END;
          stopped_nxt   = 1'b1;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  // cursor and message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      stopped_r <= 1'b1;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

>>> rtl/cnw_queue.sv
// ----------------------------------------------------------------------------
// cnw_queue
// small register fifo of bus jobs between front and back end
// ----------------------------------------------------------------------------
module cnw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cnw_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output cnw_pkg::job_t head
);

  localparam int DEPTH = cnw_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  cnw_pkg::job_t  slot_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]  count_r, count_nxt;

  assign full     = (count_r == NW'(DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = slot_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> rtl/cnw_back.sv
// ----------------------------------------------------------------------------
// cnw_back
// walks a bus job byte by byte and sends one nibble per cycle while the receiver is ready
// ----------------------------------------------------------------------------
module cnw_back (
  input  logic          clk,
  input  logic          rst_n,
  input  cnw_pkg::cfg_t cfg,
  input  logic          q_nonempty,
  input  cnw_pkg::job_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          reg_select,
  output logic [3:0]    nibble,
  output logic [16:0]   wait_after_us,
  output logic          last
);

  logic               busy_r, busy_nxt;
  cnw_pkg::job_t      job_r, job_nxt;
  logic [2:0]         idx_r, idx_nxt;
  logic               half_r, half_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               rs_r;
  logic [3:0]         nibble_r;
  logic [16:0]        wait_r;
  logic               last_r;

  cnw_pkg::job_t      cur_job;
  logic [2:0]         cur_idx;
  logic               cur_half;
  cnw_pkg::bus_byte_t cur_byte;
  logic               advance;
  logic               fire;
  logic               is_last;
  logic [3:0]         cur_nibble;
  logic [16:0]        cur_wait;

  // current job comes from the job register or straight from the queue head
  assign cur_job  = busy_r ? job_r : q_head;
  assign cur_idx  = busy_r ? idx_r : 3'd0;
  assign cur_half = busy_r ? half_r : 1'b0;
  assign cur_byte = cnw_pkg::job_byte(cur_job, cur_idx);

  assign advance = !out_valid_r || out_ready;
  assign fire    = (busy_r || q_nonempty) && advance;
  assign q_pop   = fire && !busy_r;
  assign is_last = cur_half && (cur_idx == cnw_pkg::job_bytes(cur_job.kind) - 3'd1);

  // nibble and wait after its strobe
  always_comb begin
    cur_nibble = cur_half ? cur_byte.value[3:0] : cur_byte.value[7:4];
    if (cur_half) begin
      cur_wait = 17'(cfg.strobe_width_us) + 17'(cfg.byte_wait_us)
               + (cur_byte.is_data ? 17'd0 : 17'(cfg.command_wait_us));
    end else begin
      cur_wait = 17'(cfg.strobe_width_us);
    end
  end

  // sequencing through the job
  always_comb begin
    busy_nxt      = busy_r;
    job_nxt       = job_r;
    idx_nxt       = idx_r;
    half_nxt      = half_r;
    out_valid_nxt = out_valid_r;
    if (fire) begin
      job_nxt       = cur_job;
      busy_nxt      = !is_last;
      half_nxt      = !cur_half;
      idx_nxt       = cur_half ? cur_idx + 3'd1 : cur_idx;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // job and output payload
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (fire) begin
      rs_r     <= cur_byte.is_data;
      nibble_r <= cur_nibble;
      wait_r   <= cur_wait;
      last_r   <= is_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign reg_select    = rs_r;
  assign nibble        = nibble_r;
  assign wait_after_us = wait_r;
  assign last          = last_r;

endmodule

>>> rtl/cnw_checker.sv
// ----------------------------------------------------------------------------
// cnw_checker
// port-level checks of the nibble stream, bound to the top level
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_writer_unit_assert.svh"

module cnw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  logic out_xfer;
  logic phase_r;
  logic rs_first_r;

  assign out_xfer = out_tvalid && out_tready;

  // which nibble of a byte the next transfer is
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= 1'b0;
      rs_first_r <= 1'b0;
    end else if (out_xfer) begin
      phase_r    <= !phase_r;
      rs_first_r <= out_tuser;
    end
  end

  // a stalled nibble holds
  `CNW_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled nibble changed")

  // an action always ends on the low nibble of a byte
  `CNW_ASSERT_NOW(a_last_low_nibble, out_xfer && out_tlast, phase_r, "last marked on a high nibble")

  // both nibbles of a byte share the register select level
  `CNW_ASSERT_NOW(a_rs_pair, out_xfer && phase_r, out_tuser == rs_first_r, "register select split within a byte")

endmodule

bind char_lcd_nibble_writer_unit cnw_checker u_cnw_checker (.*);

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the character lcd nibble writer
// ----------------------------------------------------------------------------
// Sends actions (init, begin, characters, end) on the input stream and checks
// every nibble transfer against a predictor that tracks the column count, the
// message state and the three wait registers. A short directed run covers
// the edge cases. Random message traffic under several register settings
// then walks through row changes and screen wraps, with random gaps on both
// streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int        SCREEN_CHARS = cnw_pkg::ROW_CHARS_DEF * cnw_pkg::ROW_COUNT_DEF;
  localparam int        SETTLE_CYCLES = 24;
  localparam int        QUIET_LIMIT = 3000;
  localparam int        HOLD_CYCLES = 400;
  localparam int        PHASE_ITEMS = 30;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // one expected nibble on the lcd bus
  typedef struct packed {
    logic        rs;
    logic [3:0]  nib;
    logic [16:0] wait_us;
    logic        last;
  } nibble_t;

  // predictor of the nibble writer plus the store of nibbles still owed
  class lcd_bus_board;
    logic [7:0]  strobe_us;
    logic [9:0]  byte_us;
    logic [15:0] cmd_us;
    int          col_count;
    bit          stopped;
    nibble_t     expected_nibbles[$];
    int          errors;
    int          busy_items;

    function new();
      strobe_us  = cnw_pkg::STROBE_WIDTH_RST;
      byte_us    = cnw_pkg::BYTE_WAIT_RST;
      cmd_us     = cnw_pkg::COMMAND_WAIT_RST;
      col_count  = 0;
      stopped    = 1'b1;
      errors     = 0;
      busy_items = 0;
    endfunction

    function void apply_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        cnw_pkg::REG_STROBE_WIDTH: strobe_us = val[7:0];
        cnw_pkg::REG_BYTE_WAIT:    byte_us   = val[9:0];
        cnw_pkg::REG_COMMAND_WAIT: cmd_us    = val;
        default: ;
      endcase
    endfunction

    // two nibbles of one bus byte, high nibble first
    function void push_byte(logic [8:0] bus_byte, bit final_byte);
      nibble_t hi;
      nibble_t lo;
      hi.rs      = bus_byte[8];
      hi.nib     = bus_byte[7:4];
      hi.wait_us = {9'b0, strobe_us};
      hi.last    = 1'b0;
      lo.rs      = bus_byte[8];
      lo.nib     = bus_byte[3:0];
      lo.wait_us = {9'b0, strobe_us} + {7'b0, byte_us}
                   + (bus_byte[8] ? 17'd0 : {1'b0, cmd_us});
      lo.last    = final_byte;
      expected_nibbles.push_back(hi);
      expected_nibbles.push_back(lo);
    endfunction

    // bytes caused by one accepted action, msb marks display data
    function void note_action(cnw_pkg::action_t act, logic [7:0] code);
      logic [8:0] seq[$];
      logic [7:0] row_addr[4];
      logic [7:0] boot_cmds[7];
      row_addr  = '{8'h00, 8'h40, 8'h14, 8'h54};
      boot_cmds = '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h04, cnw_pkg::CMD_CLEAR,
                    cnw_pkg::CMD_HOME};
      case (act)
        cnw_pkg::ACT_INIT: begin
          foreach (boot_cmds[i]) seq.push_back({1'b0, boot_cmds[i]});
          col_count = 0;
          stopped   = 1'b1;
        end
        cnw_pkg::ACT_BEGIN: begin
          seq.push_back({1'b0, cnw_pkg::CMD_CLEAR});
          seq.push_back({1'b0, cnw_pkg::CMD_HOME});
          col_count = 0;
          stopped   = 1'b0;
        end
        cnw_pkg::ACT_CHAR: begin
          if (!stopped && code == cnw_pkg::NEWLINE) begin
            stopped = 1'b1;
          end else if (!stopped) begin
            seq.push_back({1'b1, code});
            if (col_count + 1 >= SCREEN_CHARS) begin
              // screen full: home, clear, count from zero
              seq.push_back({1'b0, cnw_pkg::CMD_DDRAM});
              seq.push_back({1'b0, cnw_pkg::CMD_CLEAR});
              seq.push_back({1'b0, cnw_pkg::CMD_HOME});
              col_count = 0;
            end else begin
              // row full: jump to the start of the next row
              if ((col_count + 1) % cnw_pkg::ROW_CHARS_DEF == 0)
                seq.push_back({1'b0, cnw_pkg::CMD_DDRAM |
                               row_addr[(col_count + 1) / cnw_pkg::ROW_CHARS_DEF]});
              col_count++;
            end
          end
        end
        default: begin
          seq.push_back({1'b0, cnw_pkg::CMD_DDRAM});
          stopped = 1'b1;
        end
      endcase
      foreach (seq[i]) push_byte(seq[i], i == seq.size() - 1);
      if (seq.size() > 0) busy_items++;
    endfunction

    function void check_nibble(logic [23:0] data, logic rs, logic last);
      nibble_t want;
      if (expected_nibbles.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%t unexpected nibble: rs %0b data %h last %0b",
                   $realtime, rs, data, last);
        return;
      end
      want = expected_nibbles.pop_front();
      if (rs !== want.rs || data[3:0] !== want.nib || data[20:4] !== want.wait_us ||
          data[23:21] !== 3'b0 || last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display({"%t nibble mismatch: exp rs %0b nib %h wait %0d last %0b pad 0",
                    " / got rs %0b nib %h wait %0d last %0b pad %0d"},
                   $realtime, want.rs, want.nib, want.wait_us, want.last,
                   rs, data[3:0], data[20:4], last, data[23:21]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [1:0]  in_tuser = 2'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'h0000;

  lcd_bus_board board;
  bit           tx_calm = 1'b0;
  bit           rx_calm = 1'b0;
  int           rx_hold = 0;

  char_lcd_nibble_writer_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transfer monitors feed the predictor and the checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        board.note_action(cnw_pkg::action_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) board.check_nibble(out_tdata, out_tuser, out_tlast);
      if (cfg_valid && cfg_ready) board.apply_reg(cfg_index, cfg_data);
    end
  end

  // nibble receiver with random stalls and an optional long hold-off
  initial begin : nibble_sink
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_calm ? 0 : $urandom_range(0, 14);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // ends the run when no transfer happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // one action transfer after a random gap
  task automatic send_item(cnw_pkg::action_t act, logic [7:0] code);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= code;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop sending and wait until every owed nibble is out
  task automatic settle();
    in_tvalid <= 1'b0;
    while (board.expected_nibbles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // begin, n characters, then one of several endings
  task automatic send_message(int n_chars, int ending);
    logic [7:0] code;
    send_item(cnw_pkg::ACT_BEGIN, 8'($urandom));
    repeat (n_chars) begin
      code = 8'($urandom);
      if (code == cnw_pkg::NEWLINE) code = 8'h0B;
      send_item(cnw_pkg::ACT_CHAR, code);
    end
    case (ending)
      0: send_item(cnw_pkg::ACT_END, 8'($urandom));
      1: begin
        send_item(cnw_pkg::ACT_CHAR, cnw_pkg::NEWLINE);
        repeat ($urandom_range(0, 2)) send_item(cnw_pkg::ACT_CHAR, 8'($urandom));
      end
      2: ;
      default: begin
        send_item(cnw_pkg::ACT_END, 8'($urandom));
        send_item(cnw_pkg::ACT_CHAR, 8'($urandom));
      end
    endcase
  endtask

  // mostly well-formed messages, some init and some noise
  task automatic random_traffic(int budget);
    int target;
    int pick;
    int n;
    target = board.busy_items + budget;
    while (board.busy_items < target) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(75, 90) : $urandom_range(0, 30);
        send_message(n, $urandom_range(0, 3));
      end else if (pick == 7) begin
        send_item(cnw_pkg::ACT_INIT, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(cnw_pkg::action_t'($urandom_range(0, 3)),
                    ($urandom_range(0, 5) == 0) ? cnw_pkg::NEWLINE : 8'($urandom));
      end
    end
  endtask

  initial begin : main
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed edge cases at reset register values
    send_item(cnw_pkg::ACT_CHAR, 8'h41);      // no message open: ignored
    send_item(cnw_pkg::ACT_END, 8'h00);       // end without a message still sends ddram home
    send_item(cnw_pkg::ACT_INIT, 8'hFF);
    send_item(cnw_pkg::ACT_BEGIN, 8'h00);
    send_item(cnw_pkg::ACT_CHAR, 8'h00);
    send_item(cnw_pkg::ACT_CHAR, 8'hFF);
    send_item(cnw_pkg::ACT_CHAR, 8'h55);
    send_item(cnw_pkg::ACT_CHAR, 8'hAA);
    send_item(cnw_pkg::ACT_CHAR, cnw_pkg::NEWLINE);    // newline closes the message
    send_item(cnw_pkg::ACT_CHAR, 8'h30);      // after newline: ignored
    send_item(cnw_pkg::ACT_END, 8'hFF);
    send_item(cnw_pkg::ACT_BEGIN, cnw_pkg::NEWLINE);
    send_item(cnw_pkg::ACT_CHAR, 8'h80);
    send_item(cnw_pkg::ACT_CHAR, 8'h01);
    send_item(cnw_pkg::ACT_CHAR, 8'h7F);
    send_item(cnw_pkg::ACT_END, 8'h55);
    send_item(cnw_pkg::ACT_CHAR, 8'h31);      // after end: ignored
    send_item(cnw_pkg::ACT_INIT, cnw_pkg::NEWLINE);
    settle();

    // shortest waits
    cfg_write(cnw_pkg::REG_STROBE_WIDTH, 16'd1);
    cfg_write(cnw_pkg::REG_BYTE_WAIT, 16'd1);
    cfg_write(cnw_pkg::REG_COMMAND_WAIT, 16'd0);
    random_traffic(PHASE_ITEMS);
    settle();

    // longest waits
    cfg_write(cnw_pkg::REG_STROBE_WIDTH, 16'd255);
    cfg_write(cnw_pkg::REG_BYTE_WAIT, 16'd1023);
    cfg_write(cnw_pkg::REG_COMMAND_WAIT, 16'hFFFF);
    random_traffic(PHASE_ITEMS);
    settle();

    // upper bits dropped, unused index ignored
    cfg_write(cnw_pkg::REG_STROBE_WIDTH, 16'hFF00);
    cfg_write(cnw_pkg::REG_BYTE_WAIT, 16'hFC00);
    cfg_write(cnw_pkg::REG_COMMAND_WAIT, 16'($urandom));
    cfg_write(REG_UNUSED, 16'($urandom));
    random_traffic(PHASE_ITEMS);
    settle();

    // random values, a full screen against a held-off receiver
    cfg_write(cnw_pkg::REG_STROBE_WIDTH, 16'($urandom));
    cfg_write(cnw_pkg::REG_BYTE_WAIT, 16'($urandom));
    cfg_write(cnw_pkg::REG_COMMAND_WAIT, 16'($urandom));
    tx_calm = 1'b1;
    rx_calm = 1'b0;
    rx_hold = HOLD_CYCLES;
    send_message(SCREEN_CHARS + 2, 0);
    random_traffic(PHASE_ITEMS);
    settle();

    if (board.expected_nibbles.size() != 0) begin
      board.errors += board.expected_nibbles.size();
      $display("%0d nibbles never arrived", board.expected_nibbles.size());
    end
    if (board.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
